// ===== sv/strp_pkg.sv =====
// Package for the servo ramp PWM core: datapath ops, jump conditions,
// microcode step numbers, register indexes and the control-store function.
// No dependencies.
package strp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TMO  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd4;

	localparam logic [14:0] MIN_PULSE_RST = 15'd500;
	localparam logic [14:0] MAX_PULSE_RST = 15'd2400;
	localparam logic [7:0]  DEADZONE_RST  = 8'd2;
	localparam logic [31:0] IDLE_TMO_RST  = 32'd2000;

	localparam logic [7:0]  HOME_DEG  = 8'd90;
	localparam logic [15:0] HOME_Q8   = 16'd23040;
	localparam logic [7:0]  FULL_DEG  = 8'd180;
	localparam logic [15:0] PERIOD_US = 16'd20000;
	localparam logic [15:0] DUTY_MAX  = 16'hFFFF;

	// ceil(2^30 / 180) and ceil(2^34 / 625)
	localparam logic [22:0] RCP_DEG  = 23'd5965233;
	localparam logic [24:0] RCP_DUTY = 25'd27487791;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ELAPSED,
		OP_SPAN_MUL,
		OP_DIV_MOVE,
		OP_DIV_ITER,
		OP_INTERP,
		OP_FINISH,
		OP_PULSE_MUL,
		OP_DIV_DEG,
		OP_PULSE,
		OP_DIV_DUTY,
		OP_DUTY_Q,
		OP_DUTY_SAT,
		OP_EMIT,
		OP_IDLE_CHK,
		OP_TARGET
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_TARGET,
		COND_IDLE,
		COND_DONE,
		COND_DIV_MORE,
		COND_SAT,
		COND_NO_REDRIVE
	} cond_t;

	typedef logic [4:0] step_t;

	localparam step_t S_DISPATCH = 5'd0;
	localparam step_t S_ELAPSED  = 5'd1;
	localparam step_t S_SPAN     = 5'd2;
	localparam step_t S_DIVM     = 5'd3;
	localparam step_t S_ITERM    = 5'd4;
	localparam step_t S_INTERP   = 5'd5;
	localparam step_t S_FINISH   = 5'd6;
	localparam step_t S_DUTY     = 5'd7;
	localparam step_t S_DIVD     = 5'd8;
	localparam step_t S_PULSE    = 5'd9;
	localparam step_t S_DIVP     = 5'd10;
	localparam step_t S_DUTYQ    = 5'd11;
	localparam step_t S_SAT      = 5'd12;
	localparam step_t S_EMIT     = 5'd13;
	localparam step_t S_IDLECHK  = 5'd14;
	localparam step_t S_TGT      = 5'd15;
	localparam step_t S_REDRIVE  = 5'd16;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jmp;
	} uword_t;

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = '{op: OP_NOP, cond: COND_NEVER, jmp: S_DISPATCH};
		case (s)
			S_DISPATCH: w = '{op: OP_NOP,       cond: COND_TARGET,     jmp: S_TGT};
			S_ELAPSED:  w = '{op: OP_ELAPSED,   cond: COND_IDLE,       jmp: S_IDLECHK};
			S_SPAN:     w = '{op: OP_SPAN_MUL,  cond: COND_DONE,       jmp: S_FINISH};
			S_DIVM:     w = '{op: OP_DIV_MOVE,  cond: COND_NEVER,      jmp: S_DISPATCH};
			S_ITERM:    w = '{op: OP_DIV_ITER,  cond: COND_DIV_MORE,   jmp: S_ITERM};
			S_INTERP:   w = '{op: OP_INTERP,    cond: COND_ALWAYS,     jmp: S_DUTY};
			S_FINISH:   w = '{op: OP_FINISH,    cond: COND_NEVER,      jmp: S_DISPATCH};
			S_DUTY:     w = '{op: OP_PULSE_MUL, cond: COND_NEVER,      jmp: S_DISPATCH};
			S_DIVD:     w = '{op: OP_DIV_DEG,   cond: COND_NEVER,      jmp: S_DISPATCH};
			S_PULSE:    w = '{op: OP_PULSE,     cond: COND_NEVER,      jmp: S_DISPATCH};
			S_DIVP:     w = '{op: OP_DIV_DUTY,  cond: COND_SAT,        jmp: S_SAT};
			S_DUTYQ:    w = '{op: OP_DUTY_Q,    cond: COND_ALWAYS,     jmp: S_EMIT};
			S_SAT:      w = '{op: OP_DUTY_SAT,  cond: COND_NEVER,      jmp: S_DISPATCH};
			S_EMIT:     w = '{op: OP_EMIT,      cond: COND_NEVER,      jmp: S_DISPATCH};
			S_IDLECHK:  w = '{op: OP_IDLE_CHK,  cond: COND_ALWAYS,     jmp: S_EMIT};
			S_TGT:      w = '{op: OP_TARGET,    cond: COND_NO_REDRIVE, jmp: S_EMIT};
			S_REDRIVE:  w = '{op: OP_NOP,       cond: COND_ALWAYS,     jmp: S_DUTY};
			default:    w = '{op: OP_EMIT,      cond: COND_NEVER,      jmp: S_DISPATCH};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/servo_timed_ramp_pwm_core.sv =====
// Servo ramp PWM core: microcoded sequencer, shared 16x16 multiplier, radix-4
// serial divider for the ramp, reciprocal multipliers for the fixed divisions,
// configuration registers and output word register. Depends on strp_pkg.
//
// Usage: input words (kind, now_ms, target_angle, duration_ms) enter on
// in_valid/in_ready; each input word yields exactly one output word
// (duty, duty_written, pwm_active, angle_rounded, moving) on out_valid/
// out_ready. A target word starts a timed linear move unless it falls in
// the deadzone; an update word interpolates the angle, writes the duty and
// removes PWM after the idle timeout.
// Throughput: one word at a time; in_ready is high while the sequencer is
// idle. A mid-move update runs the elapsed, span, divide, interpolate and
// duty steps, a move's last update the finish and duty steps, an idle update
// the idle check, a target word the target step (plus the duty steps to
// re-drive the pulse); the next word is taken at the edge after out_valid
// rises. The output register holds a finished word, so the next input word
// is taken while it waits; if the receiver still stalls when the next word
// is done, the sequencer holds on its final step. Configuration writes take
// effect at once and are meant for idle periods. Reset sets the angle to 90
// degrees with pulses on, the idle timer unarmed and the registers to defaults.
module servo_timed_ramp_pwm_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [strp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [strp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           kind,
	input  logic [31:0]                    now_ms,
	input  logic [7:0]                     target_angle,
	input  logic [15:0]                    duration_ms,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [15:0]                    duty,
	output logic                           duty_written,
	output logic                           pwm_active,
	output logic [7:0]                     angle_rounded,
	output logic                           moving
);
	import strp_pkg::*;

	logic [14:0] min_pulse_q, max_pulse_q;
	logic [7:0]  deadzone_q;
	logic [31:0] idle_tmo_q;
	logic        invert_q;

	logic [15:0] cur_q, start_q;
	logic [7:0]  goal_q;
	logic [31:0] mstart_q, idle_since_q;
	logic [15:0] mlen_q;
	logic        armed_q, pulses_on_q;

	logic        busy_q;
	step_t       step_q;
	logic        kind_q;
	logic [31:0] now_q;
	logic [7:0]  tang_q;
	logic [15:0] dur_q;

	logic [31:0] t_q;
	logic        neg_q;
	logic [15:0] rem_q, dq_q, dsr_q;
	logic [2:0]  cnt_q;
	logic [15:0] pw_q;
	logic [15:0] duty_w_q;
	logic        wr_w_q;

	logic        out_valid_q;
	logic [15:0] duty_q;
	logic        duty_written_q, pwm_active_q, moving_q;
	logic [7:0]  angle_q;

	uword_t      uw;
	logic        take, emit_fire, jump;
	logic [16:0] cur_plus;
	logic [7:0]  rnd_c, ang_c, absdiff_c, a_cl, a_eff;
	logic [8:0]  diff_c;
	logic        move_c, idle_c;
	logic [16:0] span_c, span_mag, dlt_c, dlt_mag, interp_c, pulse_c;
	logic [15:0] mul_a, mul_b;
	logic [31:0] mul_c, idle_el;
	logic [45:0] deg_prod;
	logic [39:0] duty_prod;
	logic [16:0] r1, r2;
	logic        ge1, ge2;
	logic [15:0] r1s, r2s;

	assign uw        = ucode(step_q);
	assign in_ready  = !busy_q;
	assign take      = in_valid && !busy_q;
	assign emit_fire = busy_q && (uw.op == OP_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		cur_plus  = {1'b0, cur_q} + 17'd128;
		rnd_c     = cur_plus[15:8];
		ang_c     = (tang_q > FULL_DEG) ? FULL_DEG : tang_q;
		diff_c    = {1'b0, ang_c} - {1'b0, rnd_c};
		absdiff_c = diff_c[8] ? 8'(-diff_c) : diff_c[7:0];
		move_c    = absdiff_c >= deadzone_q;
		idle_el   = now_q - idle_since_q;
		idle_c    = pulses_on_q && (idle_tmo_q != 32'd0) && armed_q && (idle_el >= idle_tmo_q);

		span_c   = {1'b0, goal_q, 8'd0} - {1'b0, start_q};
		span_mag = span_c[16] ? -span_c : span_c;
		a_cl     = (cur_q[15:8] > FULL_DEG) ? FULL_DEG : cur_q[15:8];
		a_eff    = invert_q ? (FULL_DEG - a_cl) : a_cl;
		dlt_c    = {2'b00, max_pulse_q} - {2'b00, min_pulse_q};
		dlt_mag  = dlt_c[16] ? -dlt_c : dlt_c;

		if (uw.op == OP_SPAN_MUL) begin
			mul_a = span_mag[15:0];
			mul_b = t_q[15:0];
		end else begin
			mul_a = dlt_mag[15:0];
			mul_b = {8'd0, a_eff};
		end
		mul_c = {16'd0, mul_a} * {16'd0, mul_b};

		deg_prod  = {23'd0, t_q[22:0]} * {23'd0, RCP_DEG};
		duty_prod = {25'd0, pw_q[14:0]} * {15'd0, RCP_DUTY};

		interp_c = {1'b0, start_q} + (neg_q ? -{1'b0, dq_q} : {1'b0, dq_q});
		pulse_c  = {2'b00, min_pulse_q} + (neg_q ? -{1'b0, dq_q} : {1'b0, dq_q});

		r1  = {rem_q, dq_q[15]};
		ge1 = r1 >= {1'b0, dsr_q};
		r1s = ge1 ? 16'(r1 - {1'b0, dsr_q}) : r1[15:0];
		r2  = {r1s, dq_q[14]};
		ge2 = r2 >= {1'b0, dsr_q};
		r2s = ge2 ? 16'(r2 - {1'b0, dsr_q}) : r2[15:0];

		case (uw.cond)
			COND_NEVER:      jump = 1'b0;
			COND_ALWAYS:     jump = 1'b1;
			COND_TARGET:     jump = kind_q;
			COND_IDLE:       jump = (mlen_q == 16'd0);
			COND_DONE:       jump = (t_q >= {16'd0, mlen_q});
			COND_DIV_MORE:   jump = (cnt_q != 3'd7);
			COND_SAT:        jump = (pw_q >= PERIOD_US);
			COND_NO_REDRIVE: jump = !(move_c && !pulses_on_q);
			default:         jump = 1'b0;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= MIN_PULSE_RST;
			max_pulse_q <= MAX_PULSE_RST;
			deadzone_q  <= DEADZONE_RST;
			idle_tmo_q  <= IDLE_TMO_RST;
			invert_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MIN_PULSE: min_pulse_q <= cfg_wdata[14:0];
				REG_MAX_PULSE: max_pulse_q <= cfg_wdata[14:0];
				REG_DEADZONE:  deadzone_q  <= cfg_wdata[7:0];
				REG_IDLE_TMO:  idle_tmo_q  <= cfg_wdata[31:0];
				REG_INVERT:    invert_q    <= cfg_wdata[0];
				default:       ;
			endcase
		end
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			step_q       <= S_DISPATCH;
			cur_q        <= HOME_Q8;
			start_q      <= HOME_Q8;
			goal_q       <= HOME_DEG;
			mstart_q     <= 32'd0;
			mlen_q       <= 16'd0;
			idle_since_q <= 32'd0;
			armed_q      <= 1'b0;
			pulses_on_q  <= 1'b1;
		end else if (!busy_q) begin
			if (take) begin
				busy_q <= 1'b1;
				step_q <= S_DISPATCH;
			end
		end else begin
			if (uw.op == OP_EMIT) begin
				if (emit_fire) begin
					busy_q <= 1'b0;
				end
			end else begin
				step_q <= jump ? uw.jmp : step_q + 5'd1;
			end
			case (uw.op)
				OP_INTERP: cur_q <= interp_c[15:0];
				OP_FINISH: begin
					cur_q        <= {goal_q, 8'd0};
					mlen_q       <= 16'd0;
					idle_since_q <= now_q;
					armed_q      <= 1'b1;
				end
				OP_DUTY_Q, OP_DUTY_SAT: pulses_on_q <= 1'b1;
				OP_IDLE_CHK: begin
					if (idle_c) begin
						pulses_on_q <= 1'b0;
					end
				end
				OP_TARGET: begin
					idle_since_q <= now_q;
					armed_q      <= 1'b1;
					if (move_c) begin
						start_q  <= cur_q;
						goal_q   <= ang_c;
						mstart_q <= now_q;
						mlen_q   <= (dur_q == 16'd0) ? 16'd1 : dur_q;
					end
				end
				default: ;
			endcase
		end
	end

	// input latch and datapath work registers
	always_ff @(posedge clk) begin
		if (take) begin
			kind_q   <= kind;
			now_q    <= now_ms;
			tang_q   <= target_angle;
			dur_q    <= duration_ms;
			duty_w_q <= 16'd0;
			wr_w_q   <= 1'b0;
		end else if (busy_q) begin
			case (uw.op)
				OP_ELAPSED: t_q <= now_q - mstart_q;
				OP_SPAN_MUL: begin
					t_q   <= mul_c;
					neg_q <= span_c[16];
				end
				OP_PULSE_MUL: begin
					t_q   <= mul_c;
					neg_q <= dlt_c[16];
				end
				OP_DIV_MOVE: begin
					rem_q <= t_q[31:16];
					dq_q  <= t_q[15:0];
					dsr_q <= mlen_q;
					cnt_q <= 3'd0;
				end
				OP_DIV_DEG:  dq_q <= deg_prod[45:30];
				OP_DIV_DUTY: dq_q <= duty_prod[38:23];
				OP_DIV_ITER: begin
					rem_q <= r2s;
					dq_q  <= {dq_q[13:0], ge1, ge2};
					cnt_q <= cnt_q + 3'd1;
				end
				OP_PULSE: pw_q <= pulse_c[16] ? 16'd0 : pulse_c[15:0];
				OP_DUTY_Q: begin
					duty_w_q <= dq_q;
					wr_w_q   <= 1'b1;
				end
				OP_DUTY_SAT: begin
					duty_w_q <= DUTY_MAX;
					wr_w_q   <= 1'b1;
				end
				OP_IDLE_CHK: begin
					if (idle_c) begin
						duty_w_q <= 16'd0;
						wr_w_q   <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			duty_q         <= duty_w_q;
			duty_written_q <= wr_w_q;
			pwm_active_q   <= pulses_on_q;
			angle_q        <= rnd_c;
			moving_q       <= (mlen_q != 16'd0);
		end
	end

	assign out_valid     = out_valid_q;
	assign duty          = duty_q;
	assign duty_written  = duty_written_q;
	assign pwm_active    = pwm_active_q;
	assign angle_rounded = angle_q;
	assign moving        = moving_q;

endmodule

// ===== bench/tb_servo_timed_ramp_pwm_core.sv =====
// Self-checking bench for servo_timed_ramp_pwm_core: queued command words, bursty driver,
// stalling receiver, in-bench ramp/duty predictor and a field-by-field status checker.
// Depends on strp_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_servo_timed_ramp_pwm_core;
	import strp_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_WORDS = 78;

	typedef struct packed {
		logic        kind;
		logic [31:0] now;
		logic [7:0]  angle;
		logic [15:0] dur;
	} servo_cmd_t;

	typedef struct packed {
		logic [15:0] duty;
		logic        written;
		logic        active;
		logic [7:0]  angle;
		logic        moving;
	} servo_status_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  kind = 1'b0;
	logic [31:0]           now_ms = '0;
	logic [7:0]            target_angle = '0;
	logic [15:0]           duration_ms = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [15:0]           duty;
	logic                  duty_written;
	logic                  pwm_active;
	logic [7:0]            angle_rounded;
	logic                  moving;

	servo_timed_ramp_pwm_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.now_ms       (now_ms),
		.target_angle (target_angle),
		.duration_ms  (duration_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.duty         (duty),
		.duty_written (duty_written),
		.pwm_active   (pwm_active),
		.angle_rounded(angle_rounded),
		.moving       (moving)
	);

	always #5 clk = ~clk;

	// register shadows
	logic [14:0] cfg_min_pulse = MIN_PULSE_RST;
	logic [14:0] cfg_max_pulse = MAX_PULSE_RST;
	logic [7:0]  cfg_deadzone  = DEADZONE_RST;
	logic [31:0] cfg_idle_tmo  = IDLE_TMO_RST;
	logic        cfg_invert    = 1'b0;

	// ramp state
	logic [15:0] cur_q8     = HOME_Q8;
	logic [15:0] start_q8   = HOME_Q8;
	logic [7:0]  goal_deg   = HOME_DEG;
	logic [31:0] mv_start   = '0;
	logic [15:0] mv_len     = '0;
	logic [31:0] idle_ref   = '0;
	logic        idle_armed = 1'b0;
	logic        pulses_on  = 1'b1;

	servo_cmd_t    cmd_backlog[$];
	servo_status_t status_due[$];

	logic [31:0] t_ms;
	int gen_count    = 0;
	int words_driven = 0;
	int status_seen  = 0;
	int duty_writes  = 0;
	int pwm_drops    = 0;
	int moves_begun  = 0;
	int phases_run   = 0;
	int errors       = 0;
	int gap_left     = 0;
	int burst_left   = 1;
	int ready_run    = 0;
	int idle_cycles  = 0;

	function automatic logic [7:0] rounded_deg();
		logic [16:0] r;
		r = {1'b0, cur_q8} + 17'd128;
		return r[15:8];
	endfunction

	function automatic logic [15:0] pulse_duty();
		longint a, lo, hi, pulse, d;
		a = longint'(cur_q8 >> 8);
		if (a > longint'(FULL_DEG)) a = longint'(FULL_DEG);
		if (cfg_invert) a = longint'(FULL_DEG) - a;
		lo = longint'(cfg_min_pulse);
		hi = longint'(cfg_max_pulse);
		pulse = lo + ((hi - lo) * a) / longint'(FULL_DEG);
		if (pulse < 0) pulse = 0;
		d = (pulse * 65536) / longint'(PERIOD_US);
		if (d > longint'(DUTY_MAX)) d = longint'(DUTY_MAX);
		return d[15:0];
	endfunction

	task automatic advance_ramp(input logic k, input logic [31:0] now,
			input logic [7:0] ang_in, input logic [15:0] dur_in);
		servo_status_t st;
		logic [7:0] ang;
		logic [31:0] elapsed;
		int diff;
		longint span, stp;
		st = '0;
		if (k) begin
			ang = (ang_in > FULL_DEG) ? FULL_DEG : ang_in;
			idle_ref = now;
			idle_armed = 1'b1;
			diff = int'(ang) - int'(rounded_deg());
			if (diff < 0) diff = -diff;
			if (diff >= int'(cfg_deadzone)) begin
				if (!pulses_on) begin
					st.duty = pulse_duty();
					st.written = 1'b1;
					pulses_on = 1'b1;
				end
				start_q8 = cur_q8;
				goal_deg = ang;
				mv_start = now;
				mv_len = (dur_in == 16'd0) ? 16'd1 : dur_in;
				moves_begun++;
			end
		end else if (mv_len == 16'd0) begin
			if (pulses_on && cfg_idle_tmo != 32'd0 && idle_armed &&
					(now - idle_ref) >= cfg_idle_tmo) begin
				st.written = 1'b1;
				pulses_on = 1'b0;
				pwm_drops++;
			end
		end else begin
			elapsed = now - mv_start;
			if (elapsed >= 32'(mv_len)) begin
				cur_q8 = {goal_deg, 8'h00};
				mv_len = 16'd0;
				idle_ref = now;
				idle_armed = 1'b1;
			end else begin
				span = longint'({goal_deg, 8'h00}) - longint'(start_q8);
				stp = (span * longint'(elapsed)) / longint'(mv_len);
				cur_q8 = 16'(longint'(start_q8) + stp);
			end
			st.duty = pulse_duty();
			st.written = 1'b1;
			pulses_on = 1'b1;
		end
		if (st.written) duty_writes++;
		st.active = pulses_on;
		st.angle = rounded_deg();
		st.moving = (mv_len != 16'd0);
		status_due.push_back(st);
	endtask

	// driver: bursts of words with random gaps
	always @(posedge clk or negedge arst_n) begin
		servo_cmd_t c;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= 1'b0;
			now_ms <= '0;
			target_angle <= '0;
			duration_ms <= '0;
		end else begin
			if (in_valid && in_ready) begin
				advance_ramp(kind, now_ms, target_angle, duration_ms);
				words_driven++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (cmd_backlog.size() != 0) begin
					c = cmd_backlog.pop_front();
					in_valid <= 1'b1;
					kind <= c.kind;
					now_ms <= c.now;
					target_angle <= c.angle;
					duration_ms <= c.dur;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: alternating ready runs and stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_run = 0;
		end else if (ready_run == 0) begin
			if (out_ready) begin
				out_ready <= 1'b0;
				ready_run = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 6);
			end else begin
				out_ready <= 1'b1;
				ready_run = $urandom_range(1, 80);
			end
		end else begin
			ready_run--;
		end
	end

	// monitor
	always @(posedge clk) begin
		servo_status_t want;
		if (arst_n && out_valid && out_ready) begin
			status_seen++;
			if (status_due.size() == 0) begin
				$error("status word with nothing expected");
				errors++;
			end else begin
				want = status_due.pop_front();
				if (duty !== want.duty) begin
					$error("duty: expected %0d, got %0d", want.duty, duty);
					errors++;
				end
				if (duty_written !== want.written) begin
					$error("duty_written: expected %0d, got %0d", want.written, duty_written);
					errors++;
				end
				if (pwm_active !== want.active) begin
					$error("pwm_active: expected %0d, got %0d", want.active, pwm_active);
					errors++;
				end
				if (angle_rounded !== want.angle) begin
					$error("angle_rounded: expected %0d, got %0d", want.angle, angle_rounded);
					errors++;
				end
				if (moving !== want.moving) begin
					$error("moving: expected %0d, got %0d", want.moving, moving);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send(input logic k, input logic [31:0] now, input logic [7:0] ang,
			input logic [15:0] dur);
		servo_cmd_t c;
		c.kind = k;
		c.now = now;
		c.angle = ang;
		c.dur = dur;
		cmd_backlog.push_back(c);
		gen_count++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_MIN_PULSE: cfg_min_pulse = val[14:0];
			REG_MAX_PULSE: cfg_max_pulse = val[14:0];
			REG_DEADZONE:  cfg_deadzone = val[7:0];
			REG_IDLE_TMO:  cfg_idle_tmo = val;
			REG_INVERT:    cfg_invert = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] lo, input logic [31:0] hi,
			input logic [31:0] dz, input logic [31:0] tmo, input logic [31:0] inv);
		write_reg(REG_MIN_PULSE, lo);
		write_reg(REG_MAX_PULSE, hi);
		write_reg(REG_DEADZONE, dz);
		write_reg(REG_IDLE_TMO, tmo);
		write_reg(REG_INVERT, inv);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (cmd_backlog.size() != 0 || in_valid || status_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (50) @(posedge clk);
	endtask

	task automatic gen_move();
		logic [7:0] ang;
		logic [15:0] dur;
		int steps;
		ang = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(181, 255))
			: 8'($urandom_range(0, 180));
		dur = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
		steps = $urandom_range(1, 6);
		send(1'b1, t_ms, ang, dur);
		for (int i = 0; i < steps; i++) begin
			t_ms = t_ms + dur / steps + $urandom_range(0, 12);
			send(1'b0, t_ms, 8'($urandom), 16'($urandom));
		end
		if ($urandom_range(0, 1)) begin
			t_ms = t_ms + dur + 1;
			send(1'b0, t_ms, 8'($urandom), 16'($urandom));
		end
	endtask

	task automatic gen_idle();
		t_ms = t_ms + cfg_idle_tmo + $urandom_range(0, 4) - 2;
		send(1'b0, t_ms, 8'($urandom), 16'($urandom));
		t_ms = t_ms + $urandom_range(1, 50);
		send(1'b0, t_ms, 8'($urandom), 16'($urandom));
	endtask

	task automatic gen_broken();
		case ($urandom_range(0, 2))
			0: begin
				send(1'b1, t_ms, 8'($urandom), 16'($urandom_range(1, 400)));
				send(1'b0, t_ms - $urandom_range(1, 100), 8'($urandom), 16'($urandom));
			end
			1: begin
				send(1'b1, t_ms, 8'($urandom_range(0, 180)), 16'd200);
				t_ms = t_ms + $urandom_range(1, 150);
				send(1'b0, t_ms, 8'($urandom), 16'($urandom));
				send(1'b1, t_ms, 8'($urandom_range(0, 180)), 16'($urandom_range(0, 300)));
			end
			default: begin
				send(1'b1, t_ms, 8'($urandom), 16'($urandom_range(0, 300)));
				send(1'b0, t_ms, 8'($urandom), 16'($urandom));
			end
		endcase
	endtask

	task automatic gen_phase(input int n);
		int goal;
		int r;
		goal = gen_count + n;
		while (gen_count < goal) begin
			r = $urandom_range(0, 19);
			if (r <= 12) gen_move();
			else if (r <= 15) gen_idle();
			else if (r <= 17) gen_broken();
			else send(1'($urandom), $urandom, 8'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings
		send(1'b0, 32'd0, 8'd0, 16'd0);
		send(1'b1, 32'd10, 8'd255, 16'd0);
		send(1'b0, 32'd11, 8'd0, 16'd0);
		send(1'b1, 32'd20, 8'd0, 16'd100);
		send(1'b0, 32'd70, 8'hFF, 16'hFFFF);
		send(1'b0, 32'd120, 8'd0, 16'd0);
		send(1'b1, 32'd130, 8'd1, 16'd50);
		send(1'b0, 32'd2129, 8'd0, 16'd0);
		send(1'b0, 32'd2130, 8'd0, 16'd0);
		send(1'b0, 32'd4000, 8'd0, 16'd0);
		send(1'b1, 32'd4100, 8'd180, 16'hFFFF);
		send(1'b0, 32'd34100, 8'd0, 16'd0);
		send(1'b0, 32'd69635, 8'd0, 16'd0);
		send(1'b1, 32'hFFFF_FFF0, 8'd90, 16'd1000);
		send(1'b0, 32'h0000_0100, 8'd0, 16'd0);
		send(1'b0, 32'hFFFF_FFFF, 8'd0, 16'd0);
		send(1'b0, 32'd2000, 8'd0, 16'd0);
		send(1'b0, 32'hFFFF_FFFF, 8'd0, 16'd0);
		t_ms = $urandom;
		gen_phase(PHASE_WORDS);
		phases_run++;

		for (int p = 1; p < 8; p++) begin
			wait_drained();
			case (p)
				1: set_config(32'd0, 32'd20000, 32'd0, 32'd0, 32'd1);
				2: set_config(32'd20000, 32'd0, 32'd180, 32'hFFFF_FFFF, 32'd0);
				3: set_config(32'd2400, 32'd500, 32'd1, 32'd50, 32'd1);
				default: set_config($urandom_range(0, 20000), $urandom_range(0, 20000),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 180) : $urandom_range(0, 10),
					($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 500),
					$urandom_range(0, 1));
			endcase
			t_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FF00 : $urandom;
			gen_phase(PHASE_WORDS);
			phases_run++;
		end

		wait_drained();
		$display("Covered %0d command words over %0d register settings, %0d status words checked.",
			words_driven, phases_run, status_seen);
		$display("Moves started: %0d, duty writes: %0d, PWM removals: %0d.",
			moves_begun, duty_writes, pwm_drops);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/strp_pkg.sv
sv/servo_timed_ramp_pwm_core.sv
bench/tb_servo_timed_ramp_pwm_core.sv
